// ===== rtl/hsdp_pkg.sv =====
`timescale 1ns / 1ps
package hsdp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pic_width;
		logic [15:0] pic_height;
		logic [3:0]  status;
	} out_item_t;

	// payload byte handed from the scanner to the syntax walker
	typedef struct packed {
		logic [7:0] data_byte;
		logic       flush;     // stream ended after this entry
		logic       has_byte;  // data_byte is a payload byte
		logic [1:0] phase;     // scan phase at end of stream
	} tok_t;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_INSPS  = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam logic [1:0] RK_FIXED  = 2'd0;
	localparam logic [1:0] RK_PREFIX = 2'd1;
	localparam logic [1:0] RK_SUFFIX = 2'd2;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_NO_SPS    = 4'd1;
	localparam logic [3:0] ST_TRUNC     = 4'd2;
	localparam logic [3:0] ST_BAD_EG    = 4'd3;
	localparam logic [3:0] ST_BAD_CHR   = 4'd4;
	localparam logic [3:0] ST_NOT8      = 4'd5;
	localparam logic [3:0] ST_BAD_CYC   = 4'd6;
	localparam logic [3:0] ST_BAD_POC   = 4'd7;
	localparam logic [3:0] ST_BAD_CROP  = 4'd8;
	localparam logic [3:0] ST_TOO_LARGE = 4'd9;

	localparam logic [5:0] S_PROFILE = 6'd0;
	localparam logic [5:0] S_CONSTR = 6'd1;
	localparam logic [5:0] S_SPSID = 6'd2;
	localparam logic [5:0] S_CHROMA = 6'd3;
	localparam logic [5:0] S_SEPARATE = 6'd4;
	localparam logic [5:0] S_DEPTH_L = 6'd5;
	localparam logic [5:0] S_DEPTH_C = 6'd6;
	localparam logic [5:0] S_BYPASS = 6'd7;
	localparam logic [5:0] S_SCALE_PRESENT = 6'd8;
	localparam logic [5:0] S_LIST_FLAG = 6'd9;
	localparam logic [5:0] S_DELTA = 6'd10;
	localparam logic [5:0] S_FRAMENUM = 6'd11;
	localparam logic [5:0] S_POCTYPE = 6'd12;
	localparam logic [5:0] S_POCLSB = 6'd13;
	localparam logic [5:0] S_DELTAZERO = 6'd14;
	localparam logic [5:0] S_OFFNONREF = 6'd15;
	localparam logic [5:0] S_OFFTB = 6'd16;
	localparam logic [5:0] S_CYCLE = 6'd17;
	localparam logic [5:0] S_CYCOFF = 6'd18;
	localparam logic [5:0] S_REFS = 6'd19;
	localparam logic [5:0] S_GAPS = 6'd20;
	localparam logic [5:0] S_WIDTH = 6'd21;
	localparam logic [5:0] S_HEIGHT = 6'd22;
	localparam logic [5:0] S_FRAMEMBS = 6'd23;
	localparam logic [5:0] S_MBAFF = 6'd24;
	localparam logic [5:0] S_DIRECT = 6'd25;
	localparam logic [5:0] S_CROPFLAG = 6'd26;
	localparam logic [5:0] S_CL = 6'd27;
	localparam logic [5:0] S_CR = 6'd28;
	localparam logic [5:0] S_CT = 6'd29;
	localparam logic [5:0] S_CB = 6'd30;

	localparam logic [0:0] CFG_MAX_SIDE = 1'd0;
	localparam logic [0:0] CFG_MAX_AREA = 1'd1;

endpackage

// ===== rtl/hsdp_scan.sv =====
`timescale 1ns / 1ps
// Front: start-code search over a four-byte lookahead, emits payload tokens.
// One input byte per cycle unless tok_full; on last the window drains one byte per cycle unless tok_full.
module hsdp_scan
	import hsdp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_item,
	output logic     tok_valid,
	output tok_t     tok,
	input  logic     tok_full
);

	logic [7:0] win_q [4];
	logic [2:0] cnt_q;
	logic [2:0] skip_q;
	logic [1:0] phase_q;
	logic       drain_q;

	// retire position 0 (can3/can4 per model)
	logic       can3, can4;
	logic [7:0] after;
	logic       pfx3, pfx4;
	logic [2:0] pfx;
	logic [7:0] hdr;
	logic       emit_byte;
	logic [1:0] phase_n;
	logic [2:0] skip_n;
	logic       do_ret, do_shift_in, fin;

	assign full = drain_q | tok_full;
	assign do_shift_in = push & ~full;
	assign do_ret = drain_q ? (cnt_q != 3'd0) & ~tok_full : do_shift_in & (cnt_q == 3'd4);
	assign can3 = (cnt_q == 3'd4);
	assign can4 = ~drain_q;
	assign after = in_item.data_byte;
	assign fin = drain_q & (cnt_q == 3'd1) & ~tok_full;

	always_comb begin
		pfx3 = can3 && win_q[0] == 8'd0 && win_q[1] == 8'd0 && win_q[2] == 8'd1;
		pfx4 = can4 && win_q[0] == 8'd0 && win_q[1] == 8'd0 && win_q[2] == 8'd0
			&& win_q[3] == 8'd1;
		pfx = 3'd0;
		hdr = 8'd0;
		if (pfx3) begin
			pfx = 3'd3;
			hdr = win_q[3];
		end else if (pfx4) begin
			pfx = 3'd4;
			hdr = after;
		end
		phase_n = phase_q;
		skip_n = skip_q;
		emit_byte = 1'b0;
		if (skip_q != 3'd0) begin
			skip_n = skip_q - 3'd1;
		end else if (phase_q != PH_DONE) begin
			if (pfx != 3'd0) begin
				if (phase_q == PH_INSPS) begin
					phase_n = PH_DONE;
				end else if (hdr[4:0] == 5'd7) begin
					phase_n = PH_INSPS;
					skip_n = pfx;
				end else begin
					skip_n = pfx - 3'd1;
				end
			end else if (phase_q == PH_INSPS) begin
				emit_byte = 1'b1;
			end
		end
	end

	always_comb begin
		tok.data_byte = win_q[0];
		tok.has_byte = do_ret & emit_byte;
		tok.flush = fin | (do_shift_in & in_item.last & (cnt_q == 3'd0));
		tok.phase = do_ret ? phase_n : phase_q;
		tok_valid = tok.has_byte | tok.flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			skip_q <= 3'd0;
			phase_q <= PH_SEARCH;
			drain_q <= 1'b0;
			for (int i = 0; i < 4; i++) win_q[i] <= 8'd0;
		end else if (tok.flush) begin
			cnt_q <= 3'd0;
			skip_q <= 3'd0;
			phase_q <= PH_SEARCH;
			drain_q <= 1'b0;
			for (int i = 0; i < 4; i++) win_q[i] <= 8'd0;
		end else begin
			if (do_ret) begin
				skip_q <= skip_n;
				phase_q <= phase_n;
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= drain_q ? 8'd0 : in_item.data_byte;
				if (drain_q) cnt_q <= cnt_q - 3'd1;
			end else if (do_shift_in) begin
				win_q[cnt_q[1:0]] <= in_item.data_byte;
				cnt_q <= cnt_q + 3'd1;
			end
			if (do_shift_in && in_item.last) drain_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/hsdp_fifo.sv =====
`timescale 1ns / 1ps
// Short token queue between scanner and walker.
module hsdp_fifo
	import hsdp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  tok_t wdata,
	output logic full,
	input  logic rd,
	output tok_t rdata,
	output logic empty
);

	tok_t       mem_q [4];
	logic [2:0] wp_q, rp_q;

	assign full = (wp_q[1:0] == rp_q[1:0]) & (wp_q[2] != rp_q[2]);
	assign empty = wp_q == rp_q;
	assign rdata = mem_q[rp_q[1:0]];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q[1:0]] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 3'd0;
			rp_q <= 3'd0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 3'd1;
			if (rd && !empty) rp_q <= rp_q + 3'd1;
		end
	end

endmodule

// ===== rtl/hsdp_walk.sv =====
`timescale 1ns / 1ps
// Back: escape removal, bit-serial Exp-Golomb syntax walk, size checks.
// One bit per cycle while walking a byte; final checks use a multiply split in two halves.
module hsdp_walk
	import hsdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] max_side,
	input  logic [32:0] max_area,
	input  logic        tok_empty,
	input  tok_t        tok,
	output logic        tok_pop,
	output logic        res_valid,
	output out_item_t   res,
	input  logic        res_full
);

	typedef enum logic [3:0] {
		W_IDLE = 4'b0001,
		W_BITS = 4'b0010,
		W_CHK  = 4'b0100,
		W_OUT  = 4'b1000
	} wst_t;

	wst_t        st_q;
	logic [7:0]  byte_q;
	logic [2:0]  bit_q;
	logic [1:0]  zr_q;
	logic [5:0]  step_q;
	logic [1:0]  rk_q;
	logic [4:0]  left_q;
	logic [4:0]  gz_q;
	logic [31:0] fv_q;
	logic [7:0]  prof_q;
	logic [1:0]  chroma_q;
	logic        f444_q;
	logic        fonly_q;
	logic [3:0]  list_q;
	logic [6:0]  coef_q;
	logic [7:0]  lscale_q;
	logic [7:0]  poc_q;
	logic [39:0] wsum_q, hsum_q;
	logic [33:0] hc_q, vc_q;
	logic [3:0]  stat_q;
	logic        dec_q;
	logic        flush_q;
	logic [1:0]  phase_q;
	logic [1:0]  chk_q;
	logic [31:0] prod_lo_q;
	logic [39:0] prod_q;

	// bit decision
	logic        bit_v;
	logic [31:0] fv_sh;
	logic        fcomp;
	logic [31:0] fval;
	logic [5:0]  step_n;
	logic [1:0]  rk_n;
	logic [4:0]  left_n, gz_n;
	logic [31:0] fv_n;
	logic [7:0]  prof_n, lscale_n, poc_n;
	logic [1:0]  chroma_n;
	logic        f444_n, fonly_n;
	logic [3:0]  list_n;
	logic [6:0]  coef_n;
	logic [39:0] wsum_n, hsum_n;
	logic [33:0] hc_n, vc_n;
	logic [3:0]  stat_n;
	logic        dec_n;
	logic        to_size;

	function automatic logic high_prof(input logic [7:0] p);
		return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
			p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 ||
			p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 || p == 8'd135;
	endfunction

	assign bit_v = byte_q[bit_q];
	assign fv_sh = {fv_q[30:0], bit_v};

	always_comb begin
		logic [31:0] d;
		logic [7:0]  ns;
		logic [6:0]  cn;
		logic [33:0] hcx, vcy;
		step_n = step_q; rk_n = rk_q; left_n = left_q; gz_n = gz_q; fv_n = fv_q;
		prof_n = prof_q; lscale_n = lscale_q; poc_n = poc_q; chroma_n = chroma_q;
		f444_n = f444_q; fonly_n = fonly_q; list_n = list_q; coef_n = coef_q;
		wsum_n = wsum_q; hsum_n = hsum_q; hc_n = hc_q; vc_n = vc_q;
		stat_n = stat_q; dec_n = dec_q; to_size = 1'b0;
		fcomp = 1'b0; fval = 32'd0;
		d = 32'd0; ns = 8'd0; cn = 7'd0; hcx = 34'd0; vcy = 34'd0;
		if (!dec_q) begin
			case (rk_q)
				RK_FIXED: begin
					fv_n = fv_sh;
					left_n = left_q - 5'd1;
					if (left_q == 5'd1) begin
						fcomp = 1'b1;
						fval = fv_sh;
					end
				end
				RK_PREFIX: begin
					if (!bit_v) begin
						gz_n = gz_q + 5'd1;
						if (gz_q == 5'd30) begin
							stat_n = ST_BAD_EG;
							dec_n = 1'b1;
						end
					end else if (gz_q == 5'd0) begin
						fcomp = 1'b1;
					end else begin
						rk_n = RK_SUFFIX;
						left_n = gz_q;
						fv_n = 32'd0;
					end
				end
				default: begin
					fv_n = fv_sh;
					left_n = left_q - 5'd1;
					if (left_q == 5'd1) begin
						fcomp = 1'b1;
						fval = ((32'd1 << gz_q) - 32'd1) + fv_sh;
					end
				end
			endcase
		end
		if (fcomp) begin
			// default next read: ue into given step
			rk_n = RK_PREFIX; gz_n = 5'd0; fv_n = 32'd0;
			case (step_q)
				S_PROFILE: begin
					prof_n = fval[7:0]; step_n = S_CONSTR; rk_n = RK_FIXED; left_n = 5'd16;
				end
				S_CONSTR: step_n = S_SPSID;
				S_SPSID: begin
					if (high_prof(prof_q)) step_n = S_CHROMA;
					else begin
						chroma_n = 2'd1; step_n = S_FRAMENUM;
					end
				end
				S_CHROMA: begin
					if (fval > 32'd3) begin
						stat_n = ST_BAD_CHR; dec_n = 1'b1;
					end else begin
						chroma_n = fval[1:0];
						f444_n = fval == 32'd3;
						if (fval == 32'd3) begin
							step_n = S_SEPARATE; rk_n = RK_FIXED; left_n = 5'd1;
						end else step_n = S_DEPTH_L;
					end
				end
				S_SEPARATE: begin
					if (fval != 32'd0) chroma_n = 2'd0;
					step_n = S_DEPTH_L;
				end
				S_DEPTH_L: begin
					if (fval != 32'd0) begin
						stat_n = ST_NOT8; dec_n = 1'b1;
					end else step_n = S_DEPTH_C;
				end
				S_DEPTH_C: begin
					if (fval != 32'd0) begin
						stat_n = ST_NOT8; dec_n = 1'b1;
					end else begin
						step_n = S_BYPASS; rk_n = RK_FIXED; left_n = 5'd1;
					end
				end
				S_BYPASS: begin
					step_n = S_SCALE_PRESENT; rk_n = RK_FIXED; left_n = 5'd1;
				end
				S_SCALE_PRESENT: begin
					if (fval != 32'd0) begin
						list_n = 4'd0; step_n = S_LIST_FLAG; rk_n = RK_FIXED; left_n = 5'd1;
					end else step_n = S_FRAMENUM;
				end
				S_LIST_FLAG: begin
					if (fval != 32'd0) begin
						coef_n = 7'd0; lscale_n = 8'd8; step_n = S_DELTA;
					end else begin
						list_n = list_q + 4'd1;
						if (list_n < (f444_q ? 4'd12 : 4'd8)) begin
							step_n = S_LIST_FLAG; rk_n = RK_FIXED; left_n = 5'd1;
						end else step_n = S_FRAMENUM;
					end
				end
				S_DELTA: begin
					d = fval[0] ? ((fval >> 1) + 32'd1) : (32'd0 - (fval >> 1));
					ns = lscale_q + d[7:0];
					if (ns != 8'd0) lscale_n = ns;
					cn = coef_q + 7'd1;
					coef_n = cn;
					if (ns != 8'd0 && cn < (list_q < 4'd6 ? 7'd16 : 7'd64)) step_n = S_DELTA;
					else begin
						list_n = list_q + 4'd1;
						if (list_n < (f444_q ? 4'd12 : 4'd8)) begin
							step_n = S_LIST_FLAG; rk_n = RK_FIXED; left_n = 5'd1;
						end else step_n = S_FRAMENUM;
					end
				end
				S_FRAMENUM: step_n = S_POCTYPE;
				S_POCTYPE: begin
					if (fval == 32'd0) step_n = S_POCLSB;
					else if (fval == 32'd1) begin
						step_n = S_DELTAZERO; rk_n = RK_FIXED; left_n = 5'd1;
					end else if (fval == 32'd2) step_n = S_REFS;
					else begin
						stat_n = ST_BAD_POC; dec_n = 1'b1;
					end
				end
				S_POCLSB: step_n = S_REFS;
				S_DELTAZERO: step_n = S_OFFNONREF;
				S_OFFNONREF: step_n = S_OFFTB;
				S_OFFTB: step_n = S_CYCLE;
				S_CYCLE: begin
					if (fval > 32'd255) begin
						stat_n = ST_BAD_CYC; dec_n = 1'b1;
					end else begin
						poc_n = fval[7:0];
						step_n = (fval == 32'd0) ? S_REFS : S_CYCOFF;
					end
				end
				S_CYCOFF: begin
					poc_n = poc_q - 8'd1;
					step_n = (poc_n == 8'd0) ? S_REFS : S_CYCOFF;
				end
				S_REFS: begin
					step_n = S_GAPS; rk_n = RK_FIXED; left_n = 5'd1;
				end
				S_GAPS: step_n = S_WIDTH;
				S_WIDTH: begin
					wsum_n = ({8'd0, fval} + 40'd1) << 4;
					step_n = S_HEIGHT;
				end
				S_HEIGHT: begin
					hsum_n = {8'd0, fval} + 40'd1;
					step_n = S_FRAMEMBS; rk_n = RK_FIXED; left_n = 5'd1;
				end
				S_FRAMEMBS: begin
					fonly_n = fval[0];
					hsum_n = fval[0] ? (hsum_q << 4) : (hsum_q << 5);
					step_n = fval[0] ? S_DIRECT : S_MBAFF;
					rk_n = RK_FIXED; left_n = 5'd1;
				end
				S_MBAFF: begin
					step_n = S_DIRECT; rk_n = RK_FIXED; left_n = 5'd1;
				end
				S_DIRECT: begin
					step_n = S_CROPFLAG; rk_n = RK_FIXED; left_n = 5'd1;
				end
				S_CROPFLAG: begin
					if (fval != 32'd0) step_n = S_CL;
					else to_size = 1'b1;
				end
				S_CL: begin
					hc_n = {2'd0, fval}; step_n = S_CR;
				end
				S_CR: begin
					hc_n = hc_q + {2'd0, fval}; step_n = S_CT;
				end
				S_CT: begin
					vc_n = {2'd0, fval}; step_n = S_CB;
				end
				S_CB: begin
					vcy = vc_q + {2'd0, fval};
					hcx = (chroma_q == 2'd1 || chroma_q == 2'd2) ? (hc_q << 1) : hc_q;
					if (chroma_q == 2'd1) vcy = vcy << 1;
					if (!fonly_q) vcy = vcy << 1;
					if ({6'd0, hcx} >= wsum_q || {6'd0, vcy} >= hsum_q) begin
						stat_n = ST_BAD_CROP; dec_n = 1'b1;
					end else begin
						wsum_n = wsum_q - {6'd0, hcx};
						hsum_n = hsum_q - {6'd0, vcy};
						to_size = 1'b1;
					end
				end
				default: begin
					stat_n = ST_TRUNC; dec_n = 1'b1;
				end
			endcase
		end
	end

	assign tok_pop = (st_q == W_IDLE) & ~tok_empty;
	assign res_valid = st_q == W_OUT;

	always_comb begin
		res.status = flush_q ? ((phase_q == PH_SEARCH) ? ST_NO_SPS :
			(!dec_q ? ST_TRUNC : stat_q)) : stat_q;
		res.pic_width = (res.status == ST_OK) ? wsum_q[15:0] : 16'd0;
		res.pic_height = (res.status == ST_OK) ? hsum_q[15:0] : 16'd0;
	end

	always_ff @(posedge clk) begin
		if (tok_pop) byte_q <= tok.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= W_IDLE;
			bit_q <= 3'd7; zr_q <= 2'd0; step_q <= S_PROFILE; rk_q <= RK_FIXED;
			left_q <= 5'd8; gz_q <= 5'd0; fv_q <= 32'd0; prof_q <= 8'd0;
			chroma_q <= 2'd1; f444_q <= 1'b0; fonly_q <= 1'b0; list_q <= 4'd0;
			coef_q <= 7'd0; lscale_q <= 8'd8; poc_q <= 8'd0; wsum_q <= 40'd0;
			hsum_q <= 40'd0; hc_q <= 34'd0; vc_q <= 34'd0; stat_q <= ST_OK;
			dec_q <= 1'b0; flush_q <= 1'b0; phase_q <= PH_SEARCH; chk_q <= 2'd0;
			prod_lo_q <= 32'd0; prod_q <= 40'd0;
		end else begin
			case (st_q)
				W_IDLE: begin
					if (tok_pop) begin
						flush_q <= tok.flush;
						phase_q <= tok.phase;
						if (tok.has_byte) begin
							if (zr_q == 2'd2 && tok.data_byte == 8'd3) begin
								zr_q <= 2'd0;
								if (tok.flush) st_q <= W_OUT;
							end else begin
								if (tok.data_byte == 8'd0) begin
									if (zr_q != 2'd2) zr_q <= zr_q + 2'd1;
								end else zr_q <= 2'd0;
								bit_q <= 3'd7;
								st_q <= W_BITS;
							end
						end else begin
							st_q <= W_OUT;
						end
					end
				end
				W_BITS: begin
					step_q <= step_n; rk_q <= rk_n; left_q <= left_n; gz_q <= gz_n;
					fv_q <= fv_n; prof_q <= prof_n; lscale_q <= lscale_n; poc_q <= poc_n;
					chroma_q <= chroma_n; f444_q <= f444_n; fonly_q <= fonly_n;
					list_q <= list_n; coef_q <= coef_n; wsum_q <= wsum_n; hsum_q <= hsum_n;
					hc_q <= hc_n; vc_q <= vc_n; stat_q <= stat_n; dec_q <= dec_n;
					bit_q <= bit_q - 3'd1;
					if (to_size) begin
						chk_q <= 2'd0;
						st_q <= W_CHK;
					end else if (bit_q == 3'd0 || dec_n) begin
						st_q <= flush_q ? W_OUT : W_IDLE;
					end
				end
				W_CHK: begin
					// size check; product in two 16x20 halves
					chk_q <= chk_q + 2'd1;
					case (chk_q)
						2'd0: prod_lo_q <= {16'd0, wsum_q[15:0]} * {12'd0, hsum_q[19:0]};
						2'd1: prod_q <= {8'd0, prod_lo_q} +
							({8'd0, {16'd0, wsum_q[31:16]} * {12'd0, hsum_q[19:0]}} << 16);
						default: begin
							if (wsum_q == 40'd0 || hsum_q == 40'd0 ||
								wsum_q > {24'd0, max_side} || hsum_q > {24'd0, max_side} ||
								prod_q > {7'd0, max_area})
								stat_q <= ST_TOO_LARGE;
							else
								stat_q <= ST_OK;
							dec_q <= 1'b1;
							st_q <= flush_q ? W_OUT : W_IDLE;
						end
					endcase
				end
				default: begin
					if (!res_full) begin
						st_q <= W_IDLE;
						bit_q <= 3'd7; zr_q <= 2'd0; step_q <= S_PROFILE; rk_q <= RK_FIXED;
						left_q <= 5'd8; gz_q <= 5'd0; fv_q <= 32'd0; prof_q <= 8'd0;
						chroma_q <= 2'd1; f444_q <= 1'b0; fonly_q <= 1'b0; list_q <= 4'd0;
						coef_q <= 7'd0; lscale_q <= 8'd8; poc_q <= 8'd0; wsum_q <= 40'd0;
						hsum_q <= 40'd0; hc_q <= 34'd0; vc_q <= 34'd0; stat_q <= ST_OK;
						dec_q <= 1'b0; flush_q <= 1'b0;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/h264_sps_dimension_parser.sv =====
`timescale 1ns / 1ps
// Flow: a payload byte is popped from the token queue, then walked bit by bit, msb first;
//   a size check with a split multiply sets the status before the result is offered.
// Throughput: set by the bit-serial walker, which pops no byte until the last is walked;
//   the scanner takes one byte per cycle unless draining or the 4-entry queue is full.
// Reset: arst_n clears all control state; registers return to 16384 and 64M.
module h264_sps_dimension_parser
	import hsdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    in_item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [32:0] cfg_data
);

	logic [15:0] max_side_q;
	logic [32:0] max_area_q;
	logic        tok_valid, tok_full, tok_empty, tok_pop;
	tok_t        tok_w, tok_r;
	logic        res_valid;
	out_item_t   res;
	logic        outv_q;
	out_item_t   out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_side_q <= 16'd16384;
			max_area_q <= 33'd67108864;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_SIDE: max_side_q <= cfg_data[15:0];
				CFG_MAX_AREA: max_area_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hsdp_scan u_scan (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.tok_valid(tok_valid), .tok(tok_w), .tok_full(tok_full)
	);

	hsdp_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(tok_valid), .wdata(tok_w), .full(tok_full),
		.rd(tok_pop), .rdata(tok_r), .empty(tok_empty)
	);

	hsdp_walk u_walk (
		.clk(clk), .arst_n(arst_n), .max_side(max_side_q), .max_area(max_area_q),
		.tok_empty(tok_empty), .tok(tok_r), .tok_pop(tok_pop),
		.res_valid(res_valid), .res(res), .res_full(outv_q)
	);

	// output register: one result waits here while the walker starts the next stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
		end else if (res_valid && !outv_q) begin
			outv_q <= 1'b1;
		end else if (pop && outv_q) begin
			outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && !outv_q) out_q <= res;
	end

	assign empty = ~outv_q;
	assign out_item = out_q;

endmodule

// ===== tb/sv/h264_sps_dimension_parser_test.sv =====
`timescale 1ns / 1ps
module h264_sps_dimension_parser_test;
	import hsdp_pkg::*;

	// Clock, reset and the ports of the block under test
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    in_item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = CFG_MAX_SIDE;
	logic [32:0] cfg_data = '0;

	h264_sps_dimension_parser dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	localparam int CYCLE_LIMIT = 2000000;

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	out_item_t   dims_pending[$];
	bit          rx_hold = 1'b0;   // long receiver hold-off
	bit          rx_random = 1'b1; // random gaps on the pop side

	// Predictor state: one copy of the block's stream state
	logic [15:0] p_max_side;
	logic [32:0] p_max_area;
	logic [7:0]  p_look[4];
	int unsigned p_look_n, p_skip;
	logic [1:0]  p_phase;
	int unsigned p_esc;
	logic [5:0]  p_step;
	logic [1:0]  p_rk;
	int unsigned p_left, p_zeros;
	logic [31:0] p_val;
	logic [7:0]  p_profile;
	int unsigned p_chroma;
	bit          p_444;
	int unsigned p_frame_only, p_list, p_coef;
	logic [7:0]  p_last_scale, p_next_scale;
	int unsigned p_cyc_left;
	logic [63:0] p_wsum, p_hsum, p_hcrop, p_vcrop;
	logic [3:0]  p_status;
	bit          p_decided;

	function automatic void decide(logic [3:0] code);
		p_status = code;
		p_decided = 1'b1;
	endfunction

	function automatic void want_bits(logic [5:0] step, int unsigned n);
		p_step = step; p_rk = RK_FIXED; p_left = n; p_val = 0;
	endfunction

	function automatic void want_ue(logic [5:0] step);
		p_step = step; p_rk = RK_PREFIX; p_zeros = 0; p_val = 0;
	endfunction

	function automatic bit is_high_profile(logic [7:0] p);
		return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
			8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135};
	endfunction

	function automatic void advance_list();
		p_list++;
		if (p_list < (p_444 ? 12 : 8)) want_bits(S_LIST_FLAG, 1);
		else want_ue(S_FRAMENUM);
	endfunction

	function automatic void check_size();
		if (p_wsum == 0 || p_hsum == 0 || p_wsum > p_max_side || p_hsum > p_max_side ||
		    p_wsum * p_hsum > {31'd0, p_max_area})
			decide(ST_TOO_LARGE);
		else
			decide(ST_OK);
	endfunction

	function automatic void field_done(logic [31:0] v);
		logic [63:0] cx, cy, hc, vc;
		logic [31:0] d;
		case (p_step)
		S_PROFILE: begin p_profile = v[7:0]; want_bits(S_CONSTR, 16); end
		S_CONSTR: want_ue(S_SPSID);
		S_SPSID: begin
			if (is_high_profile(p_profile)) want_ue(S_CHROMA);
			else begin p_chroma = 1; want_ue(S_FRAMENUM); end
		end
		S_CHROMA: begin
			if (v > 3) decide(ST_BAD_CHR);
			else begin
				p_chroma = v; p_444 = (v == 3);
				if (v == 3) want_bits(S_SEPARATE, 1); else want_ue(S_DEPTH_L);
			end
		end
		S_SEPARATE: begin if (v != 0) p_chroma = 0; want_ue(S_DEPTH_L); end
		S_DEPTH_L: if (v != 0) decide(ST_NOT8); else want_ue(S_DEPTH_C);
		S_DEPTH_C: if (v != 0) decide(ST_NOT8); else want_bits(S_BYPASS, 1);
		S_BYPASS: want_bits(S_SCALE_PRESENT, 1);
		S_SCALE_PRESENT: begin
			if (v != 0) begin p_list = 0; want_bits(S_LIST_FLAG, 1); end
			else want_ue(S_FRAMENUM);
		end
		S_LIST_FLAG: begin
			if (v != 0) begin
				p_coef = 0; p_last_scale = 8; p_next_scale = 8; want_ue(S_DELTA);
			end else advance_list();
		end
		S_DELTA: begin
			d = v[0] ? ((v >> 1) + 1) : (32'd0 - (v >> 1));
			p_next_scale = p_last_scale + d[7:0];
			if (p_next_scale != 0) p_last_scale = p_next_scale;
			p_coef++;
			if (p_next_scale != 0 && p_coef < (p_list < 6 ? 16 : 64)) want_ue(S_DELTA);
			else advance_list();
		end
		S_FRAMENUM: want_ue(S_POCTYPE);
		S_POCTYPE: begin
			if (v == 0) want_ue(S_POCLSB);
			else if (v == 1) want_bits(S_DELTAZERO, 1);
			else if (v == 2) want_ue(S_REFS);
			else decide(ST_BAD_POC);
		end
		S_POCLSB: want_ue(S_REFS);
		S_DELTAZERO: want_ue(S_OFFNONREF);
		S_OFFNONREF: want_ue(S_OFFTB);
		S_OFFTB: want_ue(S_CYCLE);
		S_CYCLE: begin
			if (v > 255) decide(ST_BAD_CYC);
			else begin
				p_cyc_left = v;
				if (v == 0) want_ue(S_REFS); else want_ue(S_CYCOFF);
			end
		end
		S_CYCOFF: begin
			p_cyc_left--;
			if (p_cyc_left == 0) want_ue(S_REFS); else want_ue(S_CYCOFF);
		end
		S_REFS: want_bits(S_GAPS, 1);
		S_GAPS: want_ue(S_WIDTH);
		S_WIDTH: begin p_wsum = ({32'd0, v} + 1) * 16; want_ue(S_HEIGHT); end
		S_HEIGHT: begin p_hsum = {32'd0, v} + 1; want_bits(S_FRAMEMBS, 1); end
		S_FRAMEMBS: begin
			p_frame_only = v[0];
			p_hsum = p_hsum * 16 * (2 - p_frame_only);
			if (p_frame_only != 0) want_bits(S_DIRECT, 1); else want_bits(S_MBAFF, 1);
		end
		S_MBAFF: want_bits(S_DIRECT, 1);
		S_DIRECT: want_bits(S_CROPFLAG, 1);
		S_CROPFLAG: if (v != 0) want_ue(S_CL); else check_size();
		S_CL: begin p_hcrop = v; want_ue(S_CR); end
		S_CR: begin p_hcrop += v; want_ue(S_CT); end
		S_CT: begin p_vcrop = v; want_ue(S_CB); end
		S_CB: begin
			p_vcrop += v;
			cx = (p_chroma == 1 || p_chroma == 2) ? 2 : 1;
			cy = (p_chroma == 1 ? 2 : 1) * (2 - p_frame_only);
			hc = p_hcrop * cx;
			vc = p_vcrop * cy;
			if (hc >= p_wsum || vc >= p_hsum) decide(ST_BAD_CROP);
			else begin
				p_wsum -= hc; p_hsum -= vc; check_size();
			end
		end
		default: decide(ST_TRUNC);
		endcase
	endfunction

	function automatic void walk_bit(bit b);
		if (p_decided) return;
		if (p_rk == RK_FIXED) begin
			p_val = {p_val[30:0], b};
			p_left--;
			if (p_left == 0) field_done(p_val);
		end else if (p_rk == RK_PREFIX) begin
			if (!b) begin
				p_zeros++;
				if (p_zeros > 30) decide(ST_BAD_EG);
			end else if (p_zeros == 0) field_done(0);
			else begin
				p_rk = RK_SUFFIX; p_left = p_zeros; p_val = 0;
			end
		end else begin
			p_val = {p_val[30:0], b};
			p_left--;
			if (p_left == 0) field_done(((32'd1 << p_zeros) - 1) + p_val);
		end
	endfunction

	// Drops emulation-prevention bytes, then feeds the bits msb first
	function automatic void payload(logic [7:0] b);
		if (p_esc >= 2 && b == 8'h03) begin p_esc = 0; return; end
		if (b == 0) begin if (p_esc < 2) p_esc++; end
		else p_esc = 0;
		for (int k = 7; k >= 0; k--) walk_bit(b[k]);
	endfunction

	// Retires the oldest lookahead byte, testing for 3- and 4-byte start codes
	function automatic void retire(bit can3, bit can4, logic [7:0] after);
		int unsigned plen;
		logic [7:0] hdr;
		plen = 0; hdr = 0;
		if (p_skip > 0) p_skip--;
		else if (p_phase != PH_DONE) begin
			if (can3 && p_look[0] == 0 && p_look[1] == 0 && p_look[2] == 1) begin
				plen = 3; hdr = p_look[3];
			end else if (can4 && p_look[0] == 0 && p_look[1] == 0 && p_look[2] == 0 &&
			             p_look[3] == 1) begin
				plen = 4; hdr = after;
			end
			if (plen != 0) begin
				if (p_phase == PH_INSPS) p_phase = PH_DONE;
				else if (hdr[4:0] == 5'd7) begin p_phase = PH_INSPS; p_skip = plen; end
				else p_skip = plen - 1;
			end else if (p_phase == PH_INSPS) payload(p_look[0]);
		end
		for (int k = 0; k < 3; k++) p_look[k] = p_look[k + 1];
		p_look[3] = 0;
	endfunction

	function automatic void clear_stream();
		for (int k = 0; k < 4; k++) p_look[k] = 0;
		p_look_n = 0; p_skip = 0; p_phase = PH_SEARCH; p_esc = 0;
		want_bits(S_PROFILE, 8);
		p_zeros = 0; p_profile = 0; p_chroma = 1; p_444 = 0; p_frame_only = 0;
		p_list = 0; p_coef = 0; p_last_scale = 8; p_next_scale = 8; p_cyc_left = 0;
		p_wsum = 0; p_hsum = 0; p_hcrop = 0; p_vcrop = 0;
		p_status = ST_OK; p_decided = 0;
	endfunction

	// Predicts one accepted byte; queues a result when the stream ends
	function automatic void predict_byte(in_item_t it);
		out_item_t r;
		if (p_look_n == 4) begin
			retire(1, 1, it.data_byte);
			p_look[3] = it.data_byte;
		end else begin
			p_look[p_look_n] = it.data_byte;
			p_look_n++;
		end
		if (!it.last) return;
		while (p_look_n > 0) begin
			retire(p_look_n == 4, 0, 0);
			p_look_n--;
		end
		r = '0;
		if (p_phase == PH_SEARCH) r.status = ST_NO_SPS;
		else if (!p_decided) r.status = ST_TRUNC;
		else r.status = p_status;
		if (r.status == ST_OK) begin
			r.pic_width = p_wsum[15:0];
			r.pic_height = p_hsum[15:0];
		end
		dims_pending = {dims_pending, r};
		clear_stream();
	endfunction

	// Cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	// Pop side: random gap after each transfer, optional long hold-off
	initial begin
		int unsigned gap;
		gap = 0;
		forever begin
			@(posedge clk);
			if (rx_hold) pop <= 1'b0;
			else if (gap != 0) begin
				gap--;
				pop <= 1'b0;
			end else if (pop && !empty) begin
				gap = rx_random ? $urandom_range(0, 7) : 0;
				pop <= (gap == 0);
			end else pop <= 1'b1;
		end
	end

	// Result checker: each transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (dims_pending.size() == 0) begin
				$display("%0t result expected none got %p", $time, out_item);
				error_count++;
			end else begin
				out_item_t exp_r;
				exp_r = dims_pending.pop_front();
				if (out_item.pic_width !== exp_r.pic_width)
					$display("%0t pic_width expected %0d got %0d", $time,
						exp_r.pic_width, out_item.pic_width);
				if (out_item.pic_height !== exp_r.pic_height)
					$display("%0t pic_height expected %0d got %0d", $time,
						exp_r.pic_height, out_item.pic_height);
				if (out_item.status !== exp_r.status)
					$display("%0t status expected %0d got %0d", $time,
						exp_r.status, out_item.status);
				if (out_item !== exp_r) error_count++;
			end
		end
	end

	bit tx_random = 1'b1;

	// One byte transfer; push stays up across back-to-back items
	task automatic send_byte(logic [7:0] b, bit is_last);
		in_item_t it;
		int unsigned gap;
		it.data_byte = b;
		it.last = is_last;
		gap = tx_random ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		predict_byte(it);
	endtask

	// Stream builder: bits gathered msb first, then packed into bytes
	bit sbits[$];

	function automatic void put_bits(logic [31:0] v, int unsigned n);
		for (int k = n - 1; k >= 0; k--) sbits = {sbits, bit'(v[k])};
	endfunction

	function automatic void put_ue(logic [31:0] v);
		logic [32:0] c;
		int unsigned n;
		c = {1'b0, v} + 1;
		n = 0;
		while ((c >> (n + 1)) != 0) n++;
		for (int k = 0; k < n; k++) sbits = {sbits, 1'b0};
		for (int k = n; k >= 0; k--) sbits = {sbits, bit'(c[k])};
	endfunction

	// Sends prefix, header, escaped payload and optional junk tail, last on the final byte
	task automatic send_stream(logic [7:0] hdr, bit long_sc, bit trunc, int unsigned tail);
		logic [7:0] bytes[$];
		logic [7:0] b;
		int unsigned zr;
		if (!trunc) begin
			sbits = {sbits, 1'b1};
			while (sbits.size() % 8 != 0) sbits = {sbits, 1'b0};
		end else
			sbits = sbits[0 : $urandom_range(0, sbits.size() > 0 ? sbits.size() - 1 : 0)];
		if (long_sc) bytes = {bytes, 8'd0};
		bytes = {bytes, 8'd0, 8'd0, 8'd1, hdr};
		zr = 0;
		for (int i = 0; i + 8 <= sbits.size(); i += 8) begin
			for (int k = 0; k < 8; k++) b[7 - k] = sbits[i + k];
			if (zr >= 2 && b <= 3) begin bytes = {bytes, 8'd3}; zr = 0; end
			bytes = {bytes, b};
			zr = (b == 0) ? zr + 1 : 0;
		end
		sbits.delete();
		if (tail != 0) begin
			bytes = {bytes, 8'd0, 8'd0, 8'd1};
			repeat (tail) bytes = {bytes, 8'($urandom_range(0, 255))};
		end
		foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Builds the SPS bits; knobs steer toward each branch
	task automatic build_sps(logic [7:0] prof, int unsigned chroma, bit sep,
		int unsigned dl, int unsigned dc, bit scal, int unsigned poc, int unsigned cyc,
		int unsigned wmb, int unsigned hmu, bit fonly, bit crop, int unsigned cl,
		int unsigned cr, int unsigned ct, int unsigned cb);
		int unsigned nl;
		put_bits(prof, 8);
		put_bits($urandom, 16);
		put_ue($urandom_range(0, 31));
		if (is_high_profile(prof)) begin
			put_ue(chroma);
			if (chroma > 3) return;
			if (chroma == 3) put_bits(sep, 1);
			put_ue(dl); put_ue(dc);
			put_bits($urandom_range(0, 1), 1);
			put_bits(scal, 1);
			if (scal) begin
				nl = (chroma == 3) ? 12 : 8;
				for (int l = 0; l < nl; l++) begin
					bit pres;
					pres = $urandom_range(0, 1);
					put_bits(pres, 1);
					if (pres) begin
						int unsigned ncoef;
						ncoef = (l < 6) ? 16 : 64;
						// random deltas; an even code 16 ends the list early sometimes
						for (int c = 0; c < ncoef; c++) begin
							if ($urandom_range(0, 15) == 0) begin put_ue(16); break; end
							put_ue($urandom_range(0, 6));
						end
					end
				end
			end
		end
		put_ue($urandom_range(0, 12));
		put_ue(poc);
		if (poc == 0) put_ue($urandom_range(0, 12));
		else if (poc == 1) begin
			put_bits($urandom_range(0, 1), 1);
			put_ue($urandom_range(0, 100)); put_ue($urandom_range(0, 100));
			put_ue(cyc);
			if (cyc <= 255) for (int i = 0; i < cyc; i++) put_ue($urandom_range(0, 9));
		end
		put_ue($urandom_range(0, 16));
		put_bits($urandom_range(0, 1), 1);
		put_ue(wmb); put_ue(hmu);
		put_bits(fonly, 1);
		if (!fonly) put_bits($urandom_range(0, 1), 1);
		put_bits($urandom_range(0, 1), 1);
		put_bits(crop, 1);
		if (crop) begin put_ue(cl); put_ue(cr); put_ue(ct); put_ue(cb); end
	endtask

	task automatic random_sps();
		logic [7:0] prof;
		int unsigned pick;
		pick = $urandom_range(0, 3);
		prof = (pick == 0) ? $urandom_range(0, 255) : (pick == 1 ? 8'd66 :
			(pick == 2 ? 8'd100 : 8'd244));
		build_sps(prof,
			($urandom_range(0, 15) == 0) ? 4 : $urandom_range(0, 3),
			$urandom_range(0, 1),
			($urandom_range(0, 15) == 0), ($urandom_range(0, 15) == 0),
			($urandom_range(0, 5) == 0),
			($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2),
			($urandom_range(0, 15) == 0) ? 256 : $urandom_range(0, 4),
			$urandom_range(0, 3) == 0 ? $urandom_range(0, 1100) : $urandom_range(0, 120),
			$urandom_range(0, 3) == 0 ? $urandom_range(0, 1100) : $urandom_range(0, 70),
			$urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, 10), $urandom_range(0, 10),
			$urandom_range(0, 6), $urandom_range(0, 6));
	endtask

	// Sender idles until every expected result has come back
	task automatic wait_drained();
		push <= 1'b0;
		while (dims_pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_reg(logic [0:0] idx, logic [32:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		p_max_side = (idx == CFG_MAX_SIDE) ? val[15:0] : p_max_side;
		p_max_area = (idx == CFG_MAX_AREA) ? val : p_max_area;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		// plain baseline, 176x144 frame
		build_sps(66, 1, 0, 0, 0, 0, 0, 0, 10, 8, 1, 0, 0, 0, 0, 0);
		send_stream(8'h67, 0, 0, 0);
		// high profile 4:4:4 with separate planes, cropping, 4-byte start code
		build_sps(244, 3, 1, 0, 0, 1, 1, 3, 19, 9, 0, 1, 2, 3, 1, 1);
		send_stream(8'h27, 1, 0, 3);
		// not 8-bit, bad chroma, bad POC type, cycle too long, bad crop
		build_sps(100, 1, 0, 2, 0, 0, 0, 0, 4, 4, 1, 0, 0, 0, 0, 0);
		send_stream(8'h67, 0, 0, 0);
		build_sps(100, 7, 0, 0, 0, 0, 0, 0, 4, 4, 1, 0, 0, 0, 0, 0);
		send_stream(8'h67, 0, 0, 0);
		build_sps(66, 1, 0, 0, 0, 0, 3, 0, 4, 4, 1, 0, 0, 0, 0, 0);
		send_stream(8'h67, 0, 0, 0);
		build_sps(66, 1, 0, 0, 0, 0, 1, 256, 4, 4, 1, 0, 0, 0, 0, 0);
		send_stream(8'h67, 0, 0, 0);
		build_sps(66, 1, 0, 0, 0, 0, 2, 0, 0, 0, 1, 1, 8, 0, 0, 0);
		send_stream(8'h67, 0, 0, 0);
		// too large: width above max_side
		build_sps(66, 1, 0, 0, 0, 0, 2, 0, 1100, 0, 1, 0, 0, 0, 0, 0);
		send_stream(8'h67, 0, 0, 0);
		// truncated payload, header-only, and no SPS at all
		build_sps(66, 1, 0, 0, 0, 0, 0, 0, 10, 8, 1, 0, 0, 0, 0, 0);
		send_stream(8'h67, 0, 1, 0);
		send_byte(0, 0); send_byte(0, 0); send_byte(1, 0); send_byte(8'h67, 1);
		send_byte(8'hff, 1);
		send_byte(0, 0); send_byte(0, 0); send_byte(1, 1);
		// 32 leading zeros: bad Exp-Golomb code
		put_bits(66, 8); put_bits(0, 16); put_bits(0, 32);
		send_stream(8'h67, 0, 0, 0);
		// non-SPS NAL first, then an SPS
		send_byte(0, 0); send_byte(0, 0); send_byte(1, 0); send_byte(8'h68, 0);
		send_byte(8'h55, 0);
		build_sps(66, 1, 0, 0, 0, 0, 0, 0, 2, 2, 0, 0, 0, 0, 0, 0);
		send_stream(8'h67, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_random(int unsigned n_streams);
		repeat (n_streams) begin
			if ($urandom_range(0, 9) == 0) begin
				int unsigned len;
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++)
					send_byte($urandom_range(0, 3) == 0 ? $urandom_range(0, 1) :
						$urandom_range(0, 255), i == len - 1);
			end else begin
				random_sps();
				send_stream($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 8'h67,
					$urandom_range(0, 1), $urandom_range(0, 9) == 0,
					$urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
			end
		end
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps pushing, so full must rise
	task automatic test_backpressure();
		rx_hold = 1'b1;
		fork
			repeat (8) begin
				build_sps(66, 1, 0, 0, 0, 0, 0, 0, 10, 8, 1, 0, 0, 0, 0, 0);
				send_stream(8'h67, 0, 0, 0);
			end
			begin
				repeat (3000) @(posedge clk);
				rx_hold = 1'b0;
			end
		join
		rx_hold = 1'b0;
		wait_drained();
	endtask

	task automatic test_config();
		write_reg(CFG_MAX_SIDE, 16);
		write_reg(CFG_MAX_AREA, 256);
		test_random(6);
		write_reg(CFG_MAX_SIDE, 16'hffff);
		write_reg(CFG_MAX_AREA, 33'h1_0000_0000);
		test_random(6);
		write_reg(CFG_MAX_SIDE, 33'h1_ffff_0200);
		write_reg(CFG_MAX_AREA, 33'h1_ffff_ffff);
		test_random(6);
		write_reg(CFG_MAX_SIDE, 800);
		write_reg(CFG_MAX_AREA, 300000);
		test_random(6);
		write_reg(CFG_MAX_SIDE, 0);
		write_reg(CFG_MAX_AREA, 0);
		test_random(4);
		write_reg(CFG_MAX_SIDE, 16384);
		write_reg(CFG_MAX_AREA, 64 * 1024 * 1024);
	endtask

	initial begin
		p_max_side = 16384;
		p_max_area = 64 * 1024 * 1024;
		clear_stream();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_config();
		// no gaps at all for a stretch
		tx_random = 1'b0; rx_random = 1'b0;
		test_random(8);
		tx_random = 1'b1; rx_random = 1'b1;
		test_random(12);
		wait_drained();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
